>>> hw/rtl/caf_pkg.sv
// Shared types, constants and helper functions of the contrast autofocus search block.
`timescale 1ns / 1ps

package caf_pkg;

  // Field widths fixed by the register map and the request format.
  localparam int CFG_POS_W   = 19;
  localparam int CFG_STEP_W  = 17;
  localparam int ROUNDS_W    = 4;
  localparam int SCORE_FIELD_W = 32;

  // Internal positions are signed and wide enough for a position plus or minus a step.
  localparam int POS_W   = 21;
  // Width of a refinement interval length, and of one third of it.
  localparam int DIFF_W  = 19;
  localparam int THIRD_W = 18;

  // APB address width: six 32-bit registers at byte addresses 4*i.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  // Default module parameters.
  localparam int SCORE_WIDTH_DEF    = 32;
  localparam int POSITION_WIDTH_DEF = 21;

  // Register reset values.
  localparam logic [CFG_POS_W-1:0]  INITIAL_FOCUS_RST = CFG_POS_W'(650);
  localparam logic [CFG_POS_W-1:0]  FOCUS_MIN_RST     = CFG_POS_W'(450);
  localparam logic [CFG_POS_W-1:0]  FOCUS_MAX_RST     = CFG_POS_W'(500000);
  localparam logic [CFG_STEP_W-1:0] INITIAL_STEP_RST  = CFG_STEP_W'(5000);
  localparam logic [CFG_STEP_W-1:0] MAX_STEP_RST      = CFG_STEP_W'(100000);
  localparam logic [ROUNDS_W-1:0]   REFINE_ROUNDS_RST = ROUNDS_W'(8);

  // Reciprocal of three scaled by 2^20, rounded up; exact for every DIFF_W-bit value.
  localparam int DIV3_SHIFT = 20;
  localparam logic [DIFF_W-1:0] DIV3_MUL = DIFF_W'(349526);

  typedef logic signed [POS_W-1:0] pos_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BEST  = 3'd1,
    PH_RIGHT = 3'd2,
    PH_LEFT  = 3'd3,
    PH_CLIMB = 3'd4,
    PH_MID1  = 3'd5,
    PH_MID2  = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [2:0] {
    REG_INITIAL_FOCUS = 3'd0,
    REG_FOCUS_MIN     = 3'd1,
    REG_FOCUS_MAX     = 3'd2,
    REG_INITIAL_STEP  = 3'd3,
    REG_MAX_STEP      = 3'd4,
    REG_REFINE_ROUNDS = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_POS_W-1:0]  initial_focus;
    logic [CFG_POS_W-1:0]  focus_min;
    logic [CFG_POS_W-1:0]  focus_max;
    logic [CFG_STEP_W-1:0] initial_step;
    logic [CFG_STEP_W-1:0] max_step;
    logic [ROUNDS_W-1:0]   refine_rounds;
  } cfg_t;

  // One result from the search engine.
  typedef struct packed {
    logic valid;
    pos_t pos;
    logic done;
  } res_t;

  // Limit a position to [lo, hi]; when the limits cross, v < lo gives lo, else hi.
  function automatic pos_t clamp_pos(input pos_t v, input pos_t lo, input pos_t hi);
    pos_t r;
    if (v < lo) begin
      r = lo;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Divide an interval length by three with a reciprocal multiply.
  function automatic logic [THIRD_W-1:0] div3(input logic [DIFF_W-1:0] n);
    logic [2*DIFF_W-1:0] p;
    p = (2*DIFF_W)'(n) * (2*DIFF_W)'(DIV3_MUL);
    return p[DIV3_SHIFT +: THIRD_W];
  endfunction

endpackage

>>> hw/rtl/contrast_autofocus_search.sv
// Top level of the contrast autofocus search block.
`timescale 1ns / 1ps

// Contrast-detect autofocus sequencer.
// A request with in_start_req high starts a search: the block answers with the
// clamped initial lens position. Every later request carries the sharpness
// score measured at the position asked for last, and the block answers with
// the next position to set. The last answer of a search has out_done_res high
// and holds the chosen position. A score request while no search runs gives no
// answer; a start request during a search drops it and starts a new one.
// The user must write the registers over the APB port only while no search
// request is in flight; the block does not enforce this. pready is always high.
// Flow: a request is registered in the input register at its accepting edge
// and its answer is loaded into the output register when that request fires.
// One request is accepted every cycle while the receiver does not stall; the
// whole search step, including the divide by three of the refinement
// interval, is one combinational stage between the input and output registers.
// When the receiver stalls, the answer waits in the output register and the
// next request waits in the input register; in_stall rises only then.
// Reset clears the search to idle, empties both registers and restores the
// register defaults.
module contrast_autofocus_search #(
  parameter int SCORE_WIDTH    = caf_pkg::SCORE_WIDTH_DEF,
  parameter int POSITION_WIDTH = caf_pkg::POSITION_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Request channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_start_req,
  input  logic [SCORE_WIDTH-1:0]             in_score,
  // Result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [POSITION_WIDTH-1:0]   out_focus_position,
  output logic                               out_done_res,
  // Configuration port
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [caf_pkg::PADDR_W-1:0]        paddr,
  input  logic [caf_pkg::PDATA_W-1:0]        pwdata,
  output logic [caf_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);

  // Scores take at most the width of the request field.
  localparam int SCORE_KEEP = (SCORE_WIDTH < caf_pkg::SCORE_FIELD_W)
                              ? SCORE_WIDTH : caf_pkg::SCORE_FIELD_W;

  caf_pkg::cfg_t cfg;
  caf_pkg::res_t res;

  logic                  in_v_r, in_v_nxt;
  logic                  in_start_r;
  logic [SCORE_KEEP-1:0] in_score_r;
  logic                  in_accept;
  logic                  fire;

  logic                               out_v_r, out_v_nxt;
  logic signed [POSITION_WIDTH-1:0]   out_pos_r;
  logic                               out_done_r;

  assign pready = 1'b1;

  caf_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  // The registered request is processed when the output register is free or drains.
  assign fire      = in_v_r && (!out_v_r || !out_stall);
  assign in_stall  = in_v_r && !fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    if (in_accept) begin
      in_v_nxt = 1'b1;
    end else if (fire) begin
      in_v_nxt = 1'b0;
    end else begin
      in_v_nxt = in_v_r;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_start_r <= in_start_req;
      in_score_r <= in_score[SCORE_KEEP-1:0];
    end
  end

  caf_engine #(
    .SCORE_W (SCORE_KEEP)
  ) u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .start (in_start_r),
    .score (in_score_r),
    .cfg   (cfg),
    .res   (res)
  );

  // Output register: loads a new result, empties when taken, holds while stalled.
  always_comb begin
    if (fire && res.valid) begin
      out_v_nxt = 1'b1;
    end else if (!out_stall) begin
      out_v_nxt = 1'b0;
    end else begin
      out_v_nxt = out_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && res.valid) begin
      out_pos_r  <= POSITION_WIDTH'(res.pos);
      out_done_r <= res.done;
    end
  end

  assign out_valid          = out_v_r;
  assign out_focus_position = out_pos_r;
  assign out_done_res       = out_done_r;

endmodule

>>> hw/rtl/caf_cfg_regs.sv
// APB configuration registers of the contrast autofocus search block.
`timescale 1ns / 1ps

module caf_cfg_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [caf_pkg::PADDR_W-1:0]  paddr,
  input  logic [caf_pkg::PDATA_W-1:0]  pwdata,
  output logic [caf_pkg::PDATA_W-1:0]  prdata,
  output caf_pkg::cfg_t                cfg
);

  caf_pkg::cfg_t    cfg_r;
  caf_pkg::reg_idx_t reg_idx;
  logic             wr_en;

  assign reg_idx = caf_pkg::reg_idx_t'(paddr[caf_pkg::PADDR_W-1:2]);
  assign wr_en   = psel && penable && pwrite;
  assign cfg     = cfg_r;

  // Register writes complete in the access cycle; addresses beyond the map are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_focus <= caf_pkg::INITIAL_FOCUS_RST;
      cfg_r.focus_min     <= caf_pkg::FOCUS_MIN_RST;
      cfg_r.focus_max     <= caf_pkg::FOCUS_MAX_RST;
      cfg_r.initial_step  <= caf_pkg::INITIAL_STEP_RST;
      cfg_r.max_step      <= caf_pkg::MAX_STEP_RST;
      cfg_r.refine_rounds <= caf_pkg::REFINE_ROUNDS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        caf_pkg::REG_INITIAL_FOCUS: cfg_r.initial_focus <= pwdata[caf_pkg::CFG_POS_W-1:0];
        caf_pkg::REG_FOCUS_MIN:     cfg_r.focus_min     <= pwdata[caf_pkg::CFG_POS_W-1:0];
        caf_pkg::REG_FOCUS_MAX:     cfg_r.focus_max     <= pwdata[caf_pkg::CFG_POS_W-1:0];
        caf_pkg::REG_INITIAL_STEP:  cfg_r.initial_step  <= pwdata[caf_pkg::CFG_STEP_W-1:0];
        caf_pkg::REG_MAX_STEP:      cfg_r.max_step      <= pwdata[caf_pkg::CFG_STEP_W-1:0];
        caf_pkg::REG_REFINE_ROUNDS: cfg_r.refine_rounds <= pwdata[caf_pkg::ROUNDS_W-1:0];
        default: ;
      endcase
    end
  end

  // Read data follows the address directly.
  always_comb begin
    unique case (reg_idx)
      caf_pkg::REG_INITIAL_FOCUS: prdata = caf_pkg::PDATA_W'(cfg_r.initial_focus);
      caf_pkg::REG_FOCUS_MIN:     prdata = caf_pkg::PDATA_W'(cfg_r.focus_min);
      caf_pkg::REG_FOCUS_MAX:     prdata = caf_pkg::PDATA_W'(cfg_r.focus_max);
      caf_pkg::REG_INITIAL_STEP:  prdata = caf_pkg::PDATA_W'(cfg_r.initial_step);
      caf_pkg::REG_MAX_STEP:      prdata = caf_pkg::PDATA_W'(cfg_r.max_step);
      caf_pkg::REG_REFINE_ROUNDS: prdata = caf_pkg::PDATA_W'(cfg_r.refine_rounds);
      default:                    prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/caf_engine.sv
// Search state and combinational update logic of the contrast autofocus search block.
`timescale 1ns / 1ps

module caf_engine #(
  parameter int SCORE_W = caf_pkg::SCORE_FIELD_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic               start,
  input  logic [SCORE_W-1:0] score,
  input  caf_pkg::cfg_t      cfg,
  output caf_pkg::res_t      res
);

  // Search state.
  caf_pkg::phase_t phase_r, phase_nxt;
  caf_pkg::dir_t   dir_r, dir_nxt;
  caf_pkg::pos_t   cur_r, cur_nxt;
  caf_pkg::pos_t   probe_r, probe_nxt;
  caf_pkg::pos_t   low_r, low_nxt;
  caf_pkg::pos_t   high_r, high_nxt;
  logic [caf_pkg::THIRD_W-1:0]    third_r, third_nxt;
  logic [SCORE_W-1:0]             best_r, best_nxt;
  logic [SCORE_W-1:0]             right_r, right_nxt;
  logic [SCORE_W-1:0]             first_mid_r, first_mid_nxt;
  logic [caf_pkg::CFG_STEP_W-1:0] step_r, step_nxt;
  logic [caf_pkg::ROUNDS_W-1:0]   round_r, round_nxt;

  // Shared decision terms.
  caf_pkg::pos_t min_p, max_p, step_p, start_pos;
  caf_pkg::dir_t dir_left;
  logic          improve;
  logic [caf_pkg::CFG_STEP_W:0]   dbl_step;
  logic [caf_pkg::CFG_STEP_W-1:0] new_step;
  logic          in_climb;
  caf_pkg::pos_t cp_base, cp_step, cp_pos;
  caf_pkg::dir_t cp_dir;
  caf_pkg::pos_t rb_low, rb_high, rb_lo_raw, rb_hi_raw;
  caf_pkg::pos_t m1, m2;
  logic          mid_up, is_mid2;
  caf_pkg::pos_t rn_low, rn_high, rn_cur, rn_diff, rn_pos;
  logic [caf_pkg::ROUNDS_W-1:0] rn_round;
  logic [caf_pkg::THIRD_W-1:0]  rn_third;
  logic          rn_cont;

  assign min_p     = caf_pkg::pos_t'(cfg.focus_min);
  assign max_p     = caf_pkg::pos_t'(cfg.focus_max);
  assign step_p    = caf_pkg::pos_t'(step_r);
  assign start_pos = caf_pkg::clamp_pos(caf_pkg::pos_t'(cfg.initial_focus), min_p, max_p);

  // Direction choice after the two side probes: up wins whenever both sides improve.
  assign improve = score > best_r;
  always_comb begin
    if (right_r > best_r) begin
      dir_left = caf_pkg::DIR_UP;
    end else if (improve) begin
      dir_left = caf_pkg::DIR_DOWN;
    end else begin
      dir_left = caf_pkg::DIR_NONE;
    end
  end

  // Doubled climb step, limited to the maximum step.
  assign dbl_step = {step_r, 1'b0};
  assign new_step = (dbl_step < (caf_pkg::CFG_STEP_W + 1)'(cfg.max_step))
                    ? dbl_step[caf_pkg::CFG_STEP_W-1:0] : cfg.max_step;

  // Next climb probe: from the side decision or from an improving climb step.
  assign in_climb = (phase_r == caf_pkg::PH_CLIMB);
  assign cp_base  = in_climb ? probe_r : cur_r;
  assign cp_step  = in_climb ? caf_pkg::pos_t'(new_step) : step_p;
  assign cp_dir   = in_climb ? dir_r : dir_left;
  assign cp_pos   = caf_pkg::clamp_pos((cp_dir == caf_pkg::DIR_UP) ? cp_base + cp_step
                                                                   : cp_base - cp_step,
                                       min_p, max_p);

  // Refinement interval around the climb result.
  assign rb_lo_raw = cur_r - step_p;
  assign rb_hi_raw = cur_r + step_p;
  assign rb_low    = (rb_lo_raw > min_p) ? rb_lo_raw : min_p;
  assign rb_high   = (rb_hi_raw < max_p) ? rb_hi_raw : max_p;

  // Ternary step: keep the two thirds around the better mid point.
  assign m1      = low_r + caf_pkg::pos_t'(third_r);
  assign m2      = high_r - caf_pkg::pos_t'(third_r);
  assign mid_up  = first_mid_r < score;
  assign is_mid2 = (phase_r == caf_pkg::PH_MID2);

  // Interval for the next refinement round, its third and the continue test.
  assign rn_low   = is_mid2 ? (mid_up ? m1 : low_r) : rb_low;
  assign rn_high  = is_mid2 ? (mid_up ? high_r : m2) : rb_high;
  assign rn_cur   = is_mid2 ? (mid_up ? m2 : m1) : cur_r;
  assign rn_round = is_mid2 ? round_r + caf_pkg::ROUNDS_W'(1) : '0;
  assign rn_diff  = rn_high - rn_low;
  assign rn_third = caf_pkg::div3(rn_diff[caf_pkg::DIFF_W-1:0]);
  assign rn_cont  = (rn_round < cfg.refine_rounds) && (rn_low < rn_high);
  assign rn_pos   = rn_cont ? rn_low + caf_pkg::pos_t'(rn_third) : rn_cur;

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (fire) begin
      if (start) begin
        phase_nxt = caf_pkg::PH_BEST;
      end else begin
        unique case (phase_r)
          caf_pkg::PH_IDLE:  phase_nxt = caf_pkg::PH_IDLE;
          caf_pkg::PH_BEST:  phase_nxt = caf_pkg::PH_RIGHT;
          caf_pkg::PH_RIGHT: phase_nxt = caf_pkg::PH_LEFT;
          caf_pkg::PH_LEFT: begin
            if (dir_left != caf_pkg::DIR_NONE) begin
              phase_nxt = caf_pkg::PH_CLIMB;
            end else begin
              phase_nxt = rn_cont ? caf_pkg::PH_MID1 : caf_pkg::PH_IDLE;
            end
          end
          caf_pkg::PH_CLIMB: begin
            if (improve) begin
              phase_nxt = caf_pkg::PH_CLIMB;
            end else begin
              phase_nxt = rn_cont ? caf_pkg::PH_MID1 : caf_pkg::PH_IDLE;
            end
          end
          caf_pkg::PH_MID1: phase_nxt = caf_pkg::PH_MID2;
          caf_pkg::PH_MID2: phase_nxt = rn_cont ? caf_pkg::PH_MID1 : caf_pkg::PH_IDLE;
          default:          phase_nxt = phase_r;
        endcase
      end
    end
  end

  // Datapath updates and the result of each request.
  always_comb begin
    dir_nxt       = dir_r;
    cur_nxt       = cur_r;
    probe_nxt     = probe_r;
    low_nxt       = low_r;
    high_nxt      = high_r;
    third_nxt     = third_r;
    best_nxt      = best_r;
    right_nxt     = right_r;
    first_mid_nxt = first_mid_r;
    step_nxt      = step_r;
    round_nxt     = round_r;
    res.valid     = 1'b0;
    res.pos       = cur_r;
    res.done      = 1'b0;
    if (fire) begin
      if (start) begin
        cur_nxt   = start_pos;
        step_nxt  = cfg.initial_step;
        dir_nxt   = caf_pkg::DIR_NONE;
        res.valid = 1'b1;
        res.pos   = start_pos;
      end else begin
        unique case (phase_r)
          caf_pkg::PH_BEST: begin
            best_nxt  = score;
            res.valid = 1'b1;
            res.pos   = cur_r + step_p;
          end
          caf_pkg::PH_RIGHT: begin
            right_nxt = score;
            res.valid = 1'b1;
            res.pos   = cur_r - step_p;
          end
          caf_pkg::PH_LEFT: begin
            dir_nxt   = dir_left;
            res.valid = 1'b1;
            if (dir_left == caf_pkg::DIR_UP) begin
              best_nxt = right_r;
            end else if (dir_left == caf_pkg::DIR_DOWN) begin
              best_nxt = score;
            end
            if (dir_left != caf_pkg::DIR_NONE) begin
              probe_nxt = cp_pos;
              res.pos   = cp_pos;
            end else begin
              low_nxt   = rn_low;
              high_nxt  = rn_high;
              third_nxt = rn_third;
              round_nxt = rn_round;
              res.pos   = rn_pos;
              res.done  = !rn_cont;
            end
          end
          caf_pkg::PH_CLIMB: begin
            res.valid = 1'b1;
            if (improve) begin
              cur_nxt   = probe_r;
              best_nxt  = score;
              step_nxt  = new_step;
              probe_nxt = cp_pos;
              res.pos   = cp_pos;
            end else begin
              low_nxt   = rn_low;
              high_nxt  = rn_high;
              third_nxt = rn_third;
              round_nxt = rn_round;
              res.pos   = rn_pos;
              res.done  = !rn_cont;
            end
          end
          caf_pkg::PH_MID1: begin
            first_mid_nxt = score;
            res.valid     = 1'b1;
            res.pos       = m2;
          end
          caf_pkg::PH_MID2: begin
            cur_nxt   = rn_cur;
            best_nxt  = mid_up ? score : first_mid_r;
            low_nxt   = rn_low;
            high_nxt  = rn_high;
            third_nxt = rn_third;
            round_nxt = rn_round;
            res.valid = 1'b1;
            res.pos   = rn_pos;
            res.done  = !rn_cont;
          end
          default: ;
        endcase
      end
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= caf_pkg::PH_IDLE;
      dir_r       <= caf_pkg::DIR_NONE;
      cur_r       <= '0;
      probe_r     <= '0;
      low_r       <= '0;
      high_r      <= '0;
      third_r     <= '0;
      best_r      <= '0;
      right_r     <= '0;
      first_mid_r <= '0;
      step_r      <= '0;
      round_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      dir_r       <= dir_nxt;
      cur_r       <= cur_nxt;
      probe_r     <= probe_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      third_r     <= third_nxt;
      best_r      <= best_nxt;
      right_r     <= right_nxt;
      first_mid_r <= first_mid_nxt;
      step_r      <= step_nxt;
      round_r     <= round_nxt;
    end
  end

endmodule

>>> hw/rtl/caf_checker.sv
// Port-level checks of the contrast autofocus search block, bound to its top level.
`timescale 1ns / 1ps

module caf_checker #(
  parameter int POSITION_WIDTH = caf_pkg::POSITION_WIDTH_DEF
) (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_start_req,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic signed [POSITION_WIDTH-1:0]  out_focus_position,
  input logic                              out_done_res
);

  // A stalled result stays valid and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_focus_position)
                               && $stable(out_done_res))
    else $error("stalled result changed");

  // The request side stalls only behind a result that is itself stalled.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a blocked result");

  // An accepted start request followed by a free output gives a non-final result.
  a_start_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_start_req) ##1 (!out_valid || !out_stall)
    |=> out_valid && !out_done_res)
    else $error("start request not answered");

  // Reset leaves both channels empty.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("channels not empty after reset");

endmodule

bind contrast_autofocus_search caf_checker #(
  .POSITION_WIDTH (POSITION_WIDTH)
) u_caf_checker (.*);

>>> sim/tb_top.sv
// Testbench for the contrast autofocus search block with a built-in predictor.
`timescale 1ns / 1ps

module tb_top;

  localparam int CLK_HALF = 4;
  localparam int RESET_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  localparam longint SCORE_TOP = 64'd4294967295;

  // One expected lens request from the block.
  typedef struct {
    caf_pkg::pos_t pos;
    logic done;
  } lens_request_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_start_req;
  logic [caf_pkg::SCORE_FIELD_W-1:0] in_score;
  logic out_valid;
  logic out_stall;
  logic signed [caf_pkg::POS_W-1:0] out_focus_position;
  logic out_done_res;
  logic psel;
  logic penable;
  logic pwrite;
  logic [caf_pkg::PADDR_W-1:0] paddr;
  logic [caf_pkg::PDATA_W-1:0] pwdata;
  logic [caf_pkg::PDATA_W-1:0] prdata;
  logic pready;

  contrast_autofocus_search DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_start_req       (in_start_req),
    .in_score           (in_score),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_focus_position (out_focus_position),
    .out_done_res       (out_done_res),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // Register mirror used by the predictor.
  logic [caf_pkg::CFG_POS_W-1:0]  m_init_focus;
  logic [caf_pkg::CFG_POS_W-1:0]  m_min;
  logic [caf_pkg::CFG_POS_W-1:0]  m_max;
  logic [caf_pkg::CFG_STEP_W-1:0] m_step0;
  logic [caf_pkg::CFG_STEP_W-1:0] m_step_cap;
  logic [caf_pkg::ROUNDS_W-1:0]   m_rounds;

  // Predicted search state.
  caf_pkg::phase_t sp;
  caf_pkg::dir_t   sd;
  longint s_cur;
  longint s_probe;
  longint s_lo;
  longint s_hi;
  longint s_step;
  logic [caf_pkg::SCORE_FIELD_W-1:0] s_best;
  logic [caf_pkg::SCORE_FIELD_W-1:0] s_up;
  logic [caf_pkg::SCORE_FIELD_W-1:0] s_mid1;
  int s_rounds;

  // Lens position asked for last; the synthetic focus curve scores it.
  longint last_ask;
  longint crv_peak;
  int crv_shift;
  bit crv_on;

  lens_request_t expected_moves[$];

  bit idle_on;
  int useful_items;
  int searches;
  int restarts;
  int settings_used;
  int results_checked;
  int move_errors;
  int quiet_cycles;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Clamp to the focus range; crossed limits: below min gives min, else max.
  function automatic longint fit_range(input longint v);
    if (v < longint'(m_min)) begin
      return longint'(m_min);
    end
    if (v > longint'(m_max)) begin
      return longint'(m_max);
    end
    return v;
  endfunction

  function automatic longint window_third_lo();
    return s_lo + (s_hi - s_lo) / 3;
  endfunction

  function automatic longint window_third_hi();
    return s_hi - (s_hi - s_lo) / 3;
  endfunction

  // Ask for the next first mid point, or finish with the current position.
  function automatic void next_round(output longint pos, output bit done);
    if (s_rounds < int'(m_rounds) && s_lo < s_hi) begin
      sp = caf_pkg::PH_MID1;
      pos = window_third_lo();
      done = 1'b0;
    end else begin
      sp = caf_pkg::PH_IDLE;
      pos = s_cur;
      done = 1'b1;
    end
  endfunction

  // Open the refinement window around the current position.
  function automatic void open_window(output longint pos, output bit done);
    longint lo;
    longint hi;
    lo = s_cur - s_step;
    hi = s_cur + s_step;
    s_lo = (lo > longint'(m_min)) ? lo : longint'(m_min);
    s_hi = (hi < longint'(m_max)) ? hi : longint'(m_max);
    s_rounds = 0;
    next_round(pos, done);
  endfunction

  function automatic void climb_move(output longint pos, output bit done);
    s_probe = fit_range((sd == caf_pkg::DIR_UP) ? s_cur + s_step : s_cur - s_step);
    sp = caf_pkg::PH_CLIMB;
    pos = s_probe;
    done = 1'b0;
  endfunction

  // Advance the predicted search by one request; returns 1 when a result follows.
  function automatic bit predict_move(input bit start,
                                      input logic [caf_pkg::SCORE_FIELD_W-1:0] sc,
                                      output longint pos, output bit done);
    longint m1;
    longint m2;
    longint dbl;
    bit has;
    has = 1'b1;
    pos = 0;
    done = 1'b0;
    if (start) begin
      s_cur = fit_range(longint'(m_init_focus));
      s_step = longint'(m_step0);
      sd = caf_pkg::DIR_NONE;
      sp = caf_pkg::PH_BEST;
      pos = s_cur;
    end else begin
      case (sp)
        caf_pkg::PH_BEST: begin
          s_best = sc;
          sp = caf_pkg::PH_RIGHT;
          pos = s_cur + s_step;
        end
        caf_pkg::PH_RIGHT: begin
          s_up = sc;
          sp = caf_pkg::PH_LEFT;
          pos = s_cur - s_step;
        end
        caf_pkg::PH_LEFT: begin
          if (s_up > s_best) begin
            sd = caf_pkg::DIR_UP;
            s_best = s_up;
          end else if (sc > s_best) begin
            sd = caf_pkg::DIR_DOWN;
            s_best = sc;
          end else begin
            sd = caf_pkg::DIR_NONE;
          end
          if (sd != caf_pkg::DIR_NONE) begin
            climb_move(pos, done);
          end else begin
            open_window(pos, done);
          end
        end
        caf_pkg::PH_CLIMB: begin
          if (sc > s_best) begin
            dbl = s_step * 2;
            s_cur = s_probe;
            s_best = sc;
            s_step = (dbl < longint'(m_step_cap)) ? dbl : longint'(m_step_cap);
            climb_move(pos, done);
          end else begin
            open_window(pos, done);
          end
        end
        caf_pkg::PH_MID1: begin
          s_mid1 = sc;
          sp = caf_pkg::PH_MID2;
          pos = window_third_hi();
        end
        caf_pkg::PH_MID2: begin
          m1 = window_third_lo();
          m2 = window_third_hi();
          if (s_mid1 < sc) begin
            s_lo = m1;
            s_cur = m2;
            s_best = sc;
          end else begin
            s_hi = m2;
            s_cur = m1;
            s_best = s_mid1;
          end
          s_rounds = (s_rounds + 1) & 15;
          next_round(pos, done);
        end
        default: begin
          has = 1'b0;
        end
      endcase
    end
    return has;
  endfunction

  // Sharpness of a position on a peaked curve; far away it is flat at zero.
  function automatic logic [caf_pkg::SCORE_FIELD_W-1:0] curve_score(input longint p);
    longint d;
    longint drop;
    d = (p > crv_peak) ? p - crv_peak : crv_peak - p;
    drop = d << crv_shift;
    if (drop > SCORE_TOP) begin
      return '0;
    end
    return caf_pkg::SCORE_FIELD_W'(SCORE_TOP - drop);
  endfunction

  // Next score: mostly the curve when it is on, with random and extreme values.
  function automatic logic [caf_pkg::SCORE_FIELD_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 99);
    if (crv_on && r < 90) begin
      return curve_score(last_ask);
    end else if (r < 95) begin
      return $urandom();
    end
    return ($urandom_range(0, 1) == 1) ? '1 : '0;
  endfunction

  function automatic void new_curve();
    crv_peak = longint'($urandom_range(0, 720000)) - 100000;
    crv_shift = $urandom_range(0, 14);
    crv_on = ($urandom_range(0, 4) != 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Send one request and predict its result at the accepting edge.
  // The caller follows with another send_request or with release_input.
  task automatic send_request(input bit start, input logic [caf_pkg::SCORE_FIELD_W-1:0] sc);
    longint pos;
    bit done;
    lens_request_t e;
    int gap;
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_start_req = start;
    in_score = sc;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (predict_move(start, sc, pos, done)) begin
      e.pos = caf_pkg::pos_t'(pos);
      e.done = done;
      expected_moves.push_back(e);
      last_ask = pos;
      useful_items++;
    end
  endtask

  task automatic release_input();
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Hold the sender until every expected result is in and the block is quiet.
  task automatic settle_results();
    release_input();
    while (expected_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input caf_pkg::reg_idx_t idx,
                           input logic [caf_pkg::PDATA_W-1:0] val);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    penable = 1'b0;
    paddr = caf_pkg::PADDR_W'({idx, 2'b00});
    pwdata = val;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    case (idx)
      caf_pkg::REG_INITIAL_FOCUS: m_init_focus = val[caf_pkg::CFG_POS_W-1:0];
      caf_pkg::REG_FOCUS_MIN:     m_min = val[caf_pkg::CFG_POS_W-1:0];
      caf_pkg::REG_FOCUS_MAX:     m_max = val[caf_pkg::CFG_POS_W-1:0];
      caf_pkg::REG_INITIAL_STEP:  m_step0 = val[caf_pkg::CFG_STEP_W-1:0];
      caf_pkg::REG_MAX_STEP:      m_step_cap = val[caf_pkg::CFG_STEP_W-1:0];
      caf_pkg::REG_REFINE_ROUNDS: m_rounds = val[caf_pkg::ROUNDS_W-1:0];
      default: begin
      end
    endcase
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic apply_settings(input int init_focus, input int lo, input int hi,
                                input int step0, input int step_cap, input int rounds);
    settle_results();
    write_reg(caf_pkg::REG_INITIAL_FOCUS, init_focus);
    write_reg(caf_pkg::REG_FOCUS_MIN, lo);
    write_reg(caf_pkg::REG_FOCUS_MAX, hi);
    write_reg(caf_pkg::REG_INITIAL_STEP, step0);
    write_reg(caf_pkg::REG_MAX_STEP, step_cap);
    write_reg(caf_pkg::REG_REFINE_ROUNDS, rounds);
    settings_used++;
  endtask

  // One search from start to the final position, with optional restarts.
  task automatic run_search(input bit noisy);
    new_curve();
    searches++;
    send_request(1'b1, $urandom());
    while (sp != caf_pkg::PH_IDLE) begin
      if (noisy && $urandom_range(0, 49) == 0) begin
        restarts++;
        send_request(1'b1, $urandom());
      end else begin
        send_request(1'b0, pick_score());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result stall and checking
  // ---------------------------------------------------------------------------

  // Receiver stalls in random bursts while idling is on.
  initial begin : result_stall
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
        n = $urandom_range(1, 19);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // Compare each accepted result with the oldest expected lens request.
  always @(posedge clk) begin : check_results
    lens_request_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      results_checked++;
      if (expected_moves.size() == 0) begin
        if (move_errors < MAX_REPORTS) begin
          $display("Unexpected result: pos=%0d done=%0b", out_focus_position, out_done_res);
        end
        move_errors++;
      end else begin
        e = expected_moves.pop_front();
        if (out_focus_position !== e.pos || out_done_res !== e.done) begin
          if (move_errors < MAX_REPORTS) begin
            $display("Result %0d: expected pos=%0d done=%0b, got pos=%0d done=%0b",
                     results_checked, e.pos, e.done, out_focus_position, out_done_res);
          end
          move_errors++;
        end
      end
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles", quiet_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Scores while no search runs are ignored.
  task automatic test_stray_score();
    send_request(1'b0, '0);
    send_request(1'b0, '1);
    release_input();
  endtask

  // All-zero and all-one scores, and a start whose score field is full.
  task automatic test_field_extremes();
    bit hi_next;
    settle_results();
    write_reg(caf_pkg::REG_REFINE_ROUNDS, 1);
    send_request(1'b1, '1);
    hi_next = 1'b1;
    while (sp != caf_pkg::PH_IDLE) begin
      send_request(1'b0, hi_next ? '1 : '0);
      hi_next = !hi_next;
    end
    release_input();
  endtask

  // A start during a running search drops it; zero rounds finish at once.
  task automatic test_restart();
    settle_results();
    write_reg(caf_pkg::REG_REFINE_ROUNDS, 0);
    crv_peak = 20000;
    crv_shift = 4;
    crv_on = 1'b1;
    send_request(1'b1, $urandom());
    send_request(1'b0, curve_score(last_ask));
    send_request(1'b1, '0);
    while (sp != caf_pkg::PH_IDLE) begin
      send_request(1'b0, curve_score(last_ask));
    end
    release_input();
  endtask

  // Lower limit above the upper one: the lower wins and the window is empty.
  task automatic test_crossed_limits();
    settle_results();
    write_reg(caf_pkg::REG_FOCUS_MIN, 300000);
    write_reg(caf_pkg::REG_FOCUS_MAX, 100000);
    write_reg(caf_pkg::REG_INITIAL_FOCUS, 0);
    send_request(1'b1, $urandom());
    while (sp != caf_pkg::PH_IDLE) begin
      send_request(1'b0, $urandom());
    end
    release_input();
  endtask

  // Initial step above max_step: the first improving climb step is capped.
  task automatic test_step_cap();
    apply_settings(650, 0, 524287, 5000, 1000, 2);
    crv_peak = 7650;
    crv_shift = 6;
    crv_on = 1'b1;
    send_request(1'b1, $urandom());
    while (sp != caf_pkg::PH_IDLE) begin
      send_request(1'b0, curve_score(last_ask));
    end
    release_input();
  endtask

  // Random searches under the current settings; stray scores, pauses if idling.
  task automatic test_random_searches(input int target, input bit idling);
    int first;
    first = useful_items;
    idle_on = idling;
    while (useful_items - first < target) begin
      if ($urandom_range(0, 9) == 0) begin
        send_request(1'b0, $urandom());
      end
      run_search(1'b1);
      if ($urandom_range(0, 19) == 0) begin
        settle_results();
      end
    end
    release_input();
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_start_req = 1'b0;
    in_score = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    idle_on = 1'b1;
    useful_items = 0;
    searches = 0;
    restarts = 0;
    settings_used = 1;
    results_checked = 0;
    move_errors = 0;
    quiet_cycles = 0;
    last_ask = 0;
    crv_peak = 0;
    crv_shift = 0;
    crv_on = 1'b0;

    // Predictor starts from the reset state of the block.
    m_init_focus = caf_pkg::INITIAL_FOCUS_RST;
    m_min = caf_pkg::FOCUS_MIN_RST;
    m_max = caf_pkg::FOCUS_MAX_RST;
    m_step0 = caf_pkg::INITIAL_STEP_RST;
    m_step_cap = caf_pkg::MAX_STEP_RST;
    m_rounds = caf_pkg::REFINE_ROUNDS_RST;
    sp = caf_pkg::PH_IDLE;
    sd = caf_pkg::DIR_NONE;
    s_cur = 0;
    s_probe = 0;
    s_lo = 0;
    s_hi = 0;
    s_step = 0;
    s_best = '0;
    s_up = '0;
    s_mid1 = '0;
    s_rounds = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_stray_score();
    test_field_extremes();
    test_restart();
    test_crossed_limits();
    test_step_cap();

    apply_settings(0, 0, 524287, 1, 131071, 15);
    test_random_searches(300, 1'b1);
    apply_settings(524287, 0, 524287, 131071, 1, 0);
    test_random_searches(250, 1'b1);
    apply_settings($urandom_range(0, 524287), $urandom_range(0, 262143),
                   $urandom_range(262144, 524287), $urandom_range(1, 131071),
                   $urandom_range(1, 131071), $urandom_range(0, 15));
    test_random_searches(300, 1'b1);
    apply_settings(400000, 300000, 100000, $urandom_range(1, 131071), 131071, 15);
    test_random_searches(150, 1'b1);
    apply_settings($urandom_range(0, 524287), 450, 500000, $urandom_range(1, 20000),
                   $urandom_range(1, 131071), $urandom_range(0, 15));
    test_random_searches(450, 1'b0);

    settle_results();
    if (expected_moves.size() != 0) begin
      move_errors += expected_moves.size();
    end

    $display("Ran %0d searches (%0d restarts) under %0d register settings.",
             searches, restarts, settings_used);
    $display("Checked %0d results from %0d requests; %0d errors.",
             results_checked, useful_items, move_errors);
    if (move_errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
